@@ hw/rtl/mexp_pkg.sv @@
package mexp_pkg;

    localparam int MODULUS_BITS = 31;
    localparam int BASE_BITS    = 63;
    localparam int EXP_BITS     = 31;
    localparam int PROD_BITS    = 2 * MODULUS_BITS;

    // one quotient bit per cycle over the full base width
    localparam int REDUCE_STEPS = BASE_BITS;
    localparam int CNT_BITS     = $clog2(REDUCE_STEPS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(REDUCE_STEPS - 1);

    localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(1000000007);

    localparam int IN_DATA_BITS  = 96;
    localparam int OUT_DATA_BITS = 32;

    localparam int APB_ADDR_BITS = 3;
    localparam logic [APB_ADDR_BITS-3:0] REG_MODULUS = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RED_BASE,
        ST_CHECK,
        ST_RED_ACC,
        ST_RED_SQ,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;       // take a new request into the datapath
        logic acc_clear;  // force accumulator to zero
        logic step;       // one restoring-division step
        logic mul_acc;    // acc * base into the reduction register, exponent - 1
        logic mul_sq;     // base * base into the reduction register, exponent / 2
        logic wb_base;    // remainder into base on the last step
        logic wb_acc;     // remainder into accumulator on the last step
        logic out_load;   // accumulator into the result register
    } cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_odd;
        logic mod_zero;
        logic last_step;
    } status_t;

endpackage

@@ hw/rtl/modular_exponentiation_core.sv @@
// Modular exponentiation core: base ** exponent mod modulus.
// Request stream s_axis: tdata carries base_value (63 bits) and exponent (31 bits).
// Result stream m_axis: tdata carries power_result (31 bits), one per request.
// APB port: register 0 at address 0 is the modulus (31 bits, reset 1000000007);
// write it only while the core is idle.
// One request is processed at a time with square-and-multiply. The base is
// first reduced modulo the modulus; each step then does a combinational 31x31
// multiply into the reduction register and a bit-serial restoring reduction of
// its 63 bits. A request takes popcount(exponent) + floor(log2(exponent)) steps,
// at most 61. A zero exponent (or a zero modulus) goes straight to finish.
// s_axis_tready is high while the core is idle. The result sits in an output
// register; the next request is accepted while it waits, and a finished result
// is held back until the receiver has taken the previous one.
// Reset (rst_n low, asynchronous) drops any request in flight, clears the output
// valid and restores the modulus to its reset value.
module modular_exponentiation_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [62:0] base_value, [93:63] exponent, [95:94] zero
    input  logic [mexp_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [30:0] power_result, [31] zero
    output logic [mexp_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mexp_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic [mexp_pkg::MODULUS_BITS-1:0] modulus_reg;
    logic [mexp_pkg::MODULUS_BITS-1:0] power_result;
    logic                              reg_hit;
    mexp_pkg::cmd_t                    cmd;
    mexp_pkg::status_t                 status;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[mexp_pkg::APB_ADDR_BITS-1:2] == mexp_pkg::REG_MODULUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= mexp_pkg::MODULUS_RESET;
        else if (psel && penable && pwrite && pready && reg_hit)
            modulus_reg <= pwdata[mexp_pkg::MODULUS_BITS-1:0];
    end

    assign prdata = reg_hit ? 32'(modulus_reg) : 32'd0;

    mexp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mexp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .modulus      (modulus_reg),
        .base_value   (s_axis_tdata[mexp_pkg::BASE_BITS-1:0]),
        .exponent     (s_axis_tdata[mexp_pkg::BASE_BITS +: mexp_pkg::EXP_BITS]),
        .power_result (power_result)
    );

    assign m_axis_tdata = mexp_pkg::OUT_DATA_BITS'(power_result);

endmodule

@@ hw/rtl/mexp_datapath.sv @@
module mexp_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mexp_pkg::cmd_t                      cmd,
    output mexp_pkg::status_t                   status,
    input  logic [mexp_pkg::MODULUS_BITS-1:0]   modulus,
    input  logic [mexp_pkg::BASE_BITS-1:0]      base_value,
    input  logic [mexp_pkg::EXP_BITS-1:0]       exponent,
    output logic [mexp_pkg::MODULUS_BITS-1:0]   power_result
);

    logic [mexp_pkg::BASE_BITS-1:0]    red_reg;
    logic [mexp_pkg::MODULUS_BITS-1:0] rem_reg;
    logic [mexp_pkg::CNT_BITS-1:0]     cnt_reg;
    logic [mexp_pkg::MODULUS_BITS-1:0] base_reg;
    logic [mexp_pkg::MODULUS_BITS-1:0] acc_reg;
    logic [mexp_pkg::EXP_BITS-1:0]     exp_reg;
    logic [mexp_pkg::MODULUS_BITS-1:0] res_reg;

    logic [mexp_pkg::MODULUS_BITS:0]   rem_shift;
    logic [mexp_pkg::MODULUS_BITS:0]   rem_sub;
    logic [mexp_pkg::MODULUS_BITS-1:0] rem_next;
    logic [mexp_pkg::PROD_BITS-1:0]    mul_a;
    logic [mexp_pkg::PROD_BITS-1:0]    prod;

    // remainder stays below the modulus, so the shifted value fits one extra bit
    assign rem_shift = {rem_reg, red_reg[mexp_pkg::BASE_BITS-1]};
    assign rem_sub   = rem_shift - {1'b0, modulus};

    always_comb
    begin
        if (rem_shift >= {1'b0, modulus})
            rem_next = rem_sub[mexp_pkg::MODULUS_BITS-1:0];
        else
            rem_next = rem_shift[mexp_pkg::MODULUS_BITS-1:0];
    end

    assign mul_a = cmd.mul_acc ? mexp_pkg::PROD_BITS'(acc_reg)
                               : mexp_pkg::PROD_BITS'(base_reg);
    assign prod  = mul_a * mexp_pkg::PROD_BITS'(base_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            base_reg <= '0;
            acc_reg  <= '0;
            exp_reg  <= '0;
            res_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                red_reg  <= base_value;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                exp_reg  <= exponent;
                acc_reg  <= mexp_pkg::MODULUS_BITS'(1);
            end
            else if (cmd.mul_acc || cmd.mul_sq)
            begin
                red_reg <= mexp_pkg::BASE_BITS'(prod);
                rem_reg <= '0;
                cnt_reg <= '0;
                if (cmd.mul_acc)
                    exp_reg <= exp_reg - mexp_pkg::EXP_BITS'(1);
                else
                    exp_reg <= exp_reg >> 1;
            end
            else if (cmd.step)
            begin
                red_reg <= red_reg << 1;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + mexp_pkg::CNT_BITS'(1);
                if (cmd.wb_base)
                    base_reg <= rem_next;
                if (cmd.wb_acc)
                    acc_reg <= rem_next;
            end
            else if (cmd.acc_clear)
            begin
                acc_reg <= '0;
            end

            if (cmd.out_load)
                res_reg <= acc_reg;
        end
    end

    assign status.exp_zero  = (exp_reg == '0);
    assign status.exp_odd   = exp_reg[0];
    assign status.mod_zero  = (modulus == '0);
    assign status.last_step = (cnt_reg == mexp_pkg::CNT_LAST);

    assign power_result = res_reg;

endmodule

@@ hw/rtl/mexp_ctrl.sv @@
module mexp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mexp_pkg::status_t status,
    output mexp_pkg::cmd_t    cmd
);

    mexp_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mexp_pkg::ST_START;
                end
            end
            mexp_pkg::ST_START:
            begin
                // zero exponent answers 1 even for a modulus of one or zero
                if (status.exp_zero)
                    state_next = mexp_pkg::ST_FINISH;
                else if (status.mod_zero)
                begin
                    cmd.acc_clear = 1'b1;
                    state_next    = mexp_pkg::ST_FINISH;
                end
                else
                    state_next = mexp_pkg::ST_RED_BASE;
            end
            mexp_pkg::ST_RED_BASE:
            begin
                cmd.step    = 1'b1;
                cmd.wb_base = status.last_step;
                if (status.last_step)
                    state_next = mexp_pkg::ST_CHECK;
            end
            mexp_pkg::ST_CHECK:
            begin
                if (status.exp_zero)
                    state_next = mexp_pkg::ST_FINISH;
                else if (status.exp_odd)
                begin
                    cmd.mul_acc = 1'b1;
                    state_next  = mexp_pkg::ST_RED_ACC;
                end
                else
                begin
                    cmd.mul_sq = 1'b1;
                    state_next = mexp_pkg::ST_RED_SQ;
                end
            end
            mexp_pkg::ST_RED_ACC:
            begin
                cmd.step   = 1'b1;
                cmd.wb_acc = status.last_step;
                if (status.last_step)
                    state_next = mexp_pkg::ST_CHECK;
            end
            mexp_pkg::ST_RED_SQ:
            begin
                cmd.step    = 1'b1;
                cmd.wb_base = status.last_step;
                if (status.last_step)
                    state_next = mexp_pkg::ST_CHECK;
            end
            mexp_pkg::ST_FINISH:
            begin
                // wait here only while the previous result is still unclaimed
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule
